// ===== rtl/core/best_fit_block_allocator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the best-fit block allocator
// Concurrent checks clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BFA_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("allocator check failed");
`define BFA_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("allocator check failed");
`else
`define BFA_ASSERT_IMP(lbl, pre, post)
`define BFA_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== rtl/core/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg
// Types and constants shared by the best-fit allocator modules.
// ----------------------------------------------------------------------------
package bfa_pkg;
  localparam int ADDR_W = 16;
  localparam logic [17:0] HDR_BYTES = 18'd9;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NULL = 2'd1;
  localparam logic [1:0] ST_OOM  = 2'd2;

  typedef struct packed {
    logic        used;
    logic [15:0] size;
  } hdr_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    hdr_t              wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;
endpackage

// ===== rtl/core/bfa_hdr_ram.sv =====
// ----------------------------------------------------------------------------
// bfa_hdr_ram
// Header store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bfa_hdr_ram (
  input  logic            clk,
  input  bfa_pkg::ram_req_t req,
  output bfa_pkg::hdr_t   rd_data
);
  import bfa_pkg::*;

  hdr_t mem [0:(1 << ADDR_W)-1];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end
endmodule

// ===== rtl/core/best_fit_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// best_fit_block_allocator_unit
// Allocate: walks every block below top, one header read per cycle, then splits or appends.
// Free: marks the block free, then walks the heap merging free neighbours.
// Clear, null free and other ops complete from idle. Result strobed on done for one cycle.
// One transaction at a time; the next is taken at the edge that ends the result.
// Sync reset empties the heap; header RAM has no clearing pass.
// ----------------------------------------------------------------------------
module best_fit_block_allocator_unit #(
  parameter int HEAP_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  op,
  input  logic [15:0] request_size,
  input  logic [15:0] free_address,
  output logic        busy,
  output logic        done,
  output logic [15:0] payload_address,
  output logic [1:0]  status,
  output logic [16:0] top_offset
);
  import bfa_pkg::*;

  localparam logic [17:0] LIMIT = (HEAP_BYTES < 65536) ? 18'(HEAP_BYTES) : 18'd65536;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WALK  = 4'd1;
  localparam logic [3:0] S_AEND  = 4'd2;
  localparam logic [3:0] S_AFIN  = 4'd3;
  localparam logic [3:0] S_FRMW  = 4'd4;
  localparam logic [3:0] S_MST   = 4'd5;
  localparam logic [3:0] S_MCUR  = 4'd6;
  localparam logic [3:0] S_MNXT  = 4'd7;
  localparam logic [3:0] S_MRE   = 4'd8;

  logic [3:0]  state;
  logic [16:0] top;
  logic [16:0] cur;
  logic [17:0] nxt_reg;
  logic [15:0] req;
  logic [15:0] faddr;
  logic [15:0] best;
  logic [15:0] best_len;
  logic        found;
  logic [15:0] cur_size;

  ram_req_t ram;
  hdr_t     rd;

  bfa_hdr_ram u_ram (.clk(clk), .req(ram), .rd_data(rd));

  // walk arithmetic on the header that just came out of the RAM
  logic [17:0] nxt;
  logic        fits;
  logic [17:0] new_top;
  logic [17:0] split_at;
  assign nxt      = {1'b0, cur} + {2'b00, rd.size} + HDR_BYTES;
  assign fits     = !rd.used && (rd.size >= req) && (!found || rd.size < best_len);
  assign new_top  = {1'b0, top} + {2'b00, req} + HDR_BYTES;
  assign split_at = {2'b00, best} + {2'b00, req} + HDR_BYTES;

  assign busy       = (state != S_IDLE);
  assign top_offset = top;

  always_comb begin
    ram = '0;
    case (state)
      S_IDLE: begin
        if (start && op == OP_ALLOC && top != 17'd0) begin
          ram.re = 1'b1;
        end else if (start && op == OP_FREE && free_address >= 16'(HDR_BYTES)) begin
          ram.re    = 1'b1;
          ram.raddr = free_address - 16'(HDR_BYTES);
        end
      end
      S_WALK, S_MCUR: begin
        // prefetch the following header while this one is judged
        ram.re    = (nxt < {1'b0, top});
        ram.raddr = nxt[15:0];
      end
      S_AEND: begin
        if (!found) begin
          ram.we    = !(new_top > LIMIT || {1'b0, top} + HDR_BYTES > 18'h0FFFF);
          ram.waddr = top[15:0];
          ram.wdata = '{used: 1'b1, size: req};
        end else if ({2'b00, best_len} > {2'b00, req} + HDR_BYTES) begin
          ram.we    = 1'b1;
          ram.waddr = split_at[15:0];
          ram.wdata = '{used: 1'b0, size: best_len - req - 16'(HDR_BYTES)};
        end
      end
      S_AFIN: begin
        ram.we    = 1'b1;
        ram.waddr = best;
        ram.wdata = '{used: 1'b1, size: req};
      end
      S_FRMW: begin
        ram.we    = 1'b1;
        ram.waddr = faddr - 16'(HDR_BYTES);
        ram.wdata = '{used: 1'b0, size: rd.size};
      end
      S_MST: begin
        ram.re = (top != 17'd0);
      end
      S_MNXT: begin
        if (!rd.used) begin
          ram.we    = 1'b1;
          ram.waddr = cur[15:0];
          ram.wdata = '{used: 1'b0, size: cur_size + rd.size + 16'(HDR_BYTES)};
        end else begin
          ram.re    = 1'b1;
          ram.raddr = nxt_reg[15:0];
        end
      end
      S_MRE: begin
        ram.re    = 1'b1;
        ram.raddr = cur[15:0];
      end
      default: ram = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      top   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            req             <= request_size;
            faddr           <= free_address;
            cur             <= '0;
            found           <= 1'b0;
            payload_address <= '0;
            status          <= ST_OK;
            case (op)
              OP_ALLOC: state <= (top != 17'd0) ? S_WALK : S_AEND;
              OP_FREE: begin
                if (free_address == 16'd0) begin
                  status <= ST_NULL;
                  done   <= 1'b1;
                end else if (free_address >= 16'(HDR_BYTES)) begin
                  state <= S_FRMW;
                end else begin
                  state <= S_MST;
                end
              end
              OP_CLEAR: begin
                top  <= '0;
                done <= 1'b1;
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_WALK: begin
          if (fits) begin
            best      <= cur[15:0];
            best_len  <= rd.size;
            found     <= 1'b1;
          end
          cur <= nxt[16:0];
          if (!(nxt < {1'b0, top})) begin
            state <= S_AEND;
          end
        end
        S_AEND: begin
          if (!found) begin
            // append at the top, or report out of memory
            if (new_top > LIMIT || {1'b0, top} + HDR_BYTES > 18'h0FFFF) begin
              status <= ST_OOM;
            end else begin
              payload_address <= top[15:0] + 16'(HDR_BYTES);
              top             <= new_top[16:0];
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            // absorb the slack when the remainder cannot hold a block
            if (!({2'b00, best_len} > {2'b00, req} + HDR_BYTES)) begin
              req <= best_len;
            end
            state <= S_AFIN;
          end
        end
        S_AFIN: begin
          payload_address <= best + 16'(HDR_BYTES);
          done            <= 1'b1;
          state           <= S_IDLE;
        end
        S_FRMW: state <= S_MST;
        S_MST: begin
          cur <= '0;
          if (top == 17'd0) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_MCUR;
          end
        end
        S_MCUR: begin
          cur_size <= rd.size;
          nxt_reg  <= nxt;
          if (nxt < {1'b0, top} && !rd.used) begin
            state <= S_MNXT;
          end else begin
            cur <= nxt[16:0];
            if (!(nxt < {1'b0, top})) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        S_MNXT: begin
          if (!rd.used) begin
            state <= S_MRE;
          end else begin
            cur   <= nxt_reg[16:0];
            state <= S_MCUR;
          end
        end
        S_MRE: state <= S_MCUR;
        default: state <= S_IDLE;
      endcase
    end
  end

`include "best_fit_block_allocator_unit_assert.svh"
  `BFA_ASSERT_IMP(a_done_idle, done, !busy)
  `BFA_ASSERT_NEXT(a_alloc_busy, start && !busy && op == OP_ALLOC, busy)
  `BFA_ASSERT_IMP(a_top_limit, 1'b1, {1'b0, top} <= LIMIT)
  `BFA_ASSERT_IMP(a_status_code, done, status <= ST_OOM)
endmodule
